// ----- rtl/graph6_adjacency_decoder_unit_macros.svh -----
// Assertion macros for the graph6 decoder checker.
`ifndef GRAPH6_ADJACENCY_DECODER_UNIT_MACROS_SVH
`define GRAPH6_ADJACENCY_DECODER_UNIT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define GADU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GADU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gadu_pkg.sv -----
// Types and constants shared by the graph6 decoder modules.
package gadu_pkg;

    localparam int CHAR_W        = 8;
    localparam int KIND_W        = 2;
    localparam int VC_W          = 11;
    localparam int IDX_W         = 10;
    localparam int ERR_W         = 2;
    localparam int ACC_W         = 36;
    localparam int CNT_W         = 17;
    localparam int PAIR_W        = 2 * CNT_W;
    localparam int BITS_PER_CHAR = 6;
    localparam int HPOS_W        = 3;
    localparam int NBITS_W       = 3;
    localparam int CMDQ_DEPTH    = 2;

    localparam logic [CHAR_W-1:0]        CODE_BIAS    = 8'd63;
    localparam logic [CHAR_W-1:0]        CODE_TOP     = 8'd126;
    localparam logic [CHAR_W-1:0]        CHAR_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0]        CHAR_AMP     = 8'h26;
    localparam logic [BITS_PER_CHAR-1:0] ESCAPE_VALUE = 6'd63;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LONG   = 2'd1,
        PH_DATA   = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_SIZE  = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_CHAR  = 2'd1,
        ERR_TOO_LARGE = 2'd2,
        ERR_PREFIX    = 2'd3
    } t_err;

    // Work item handed from the front end to the back end.
    typedef struct packed {
        logic                     is_data;
        t_kind                    kind;
        t_err                     err;
        logic [CNT_W-1:0]         count;
        logic [BITS_PER_CHAR-1:0] bits;
        logic [NBITS_W-1:0]       nbits;
        logic                     last_char;
    } t_cmd;

    typedef struct packed {
        t_kind            kind;
        logic [VC_W-1:0]  vertex_count;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             present;
        t_err             error_code;
        logic             last_in_run;
        logic             graph_done;
    } t_res;

endpackage

// ----- rtl/gadu_ifs.sv -----
// Handshake interfaces for the character input and the result output.
interface gadu_char_if;
    import gadu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              new_graph;

    modport source (output valid, output char_code, output new_graph, input ready);
    modport sink   (input valid, input char_code, input new_graph, output ready);
endinterface

interface gadu_res_if;
    import gadu_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VC_W-1:0]   vertex_count;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              present;
    logic [ERR_W-1:0]  error_code;
    logic              last_in_run;
    logic              graph_done;

    modport source (output valid, output kind, output vertex_count, output row, output col,
                    output present, output error_code, output last_in_run,
                    output graph_done, input ready);
    modport sink   (input valid, input kind, input vertex_count, input row, input col,
                    input present, input error_code, input last_in_run,
                    input graph_done, output ready);
endinterface

// ----- rtl/gadu_front.sv -----
// Front end: header parsing, character checks and data-bit budgeting.
module gadu_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [gadu_pkg::CHAR_W-1:0] i_char_code,
    input  logic                      i_new_graph,
    input  logic                      i_full,
    output logic                      o_push,
    output gadu_pkg::t_cmd            o_cmd
);
    import gadu_pkg::*;

    t_phase              r_phase, n_phase;
    logic [HPOS_W-1:0]   r_hpos, n_hpos;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [PAIR_W-1:0]   r_bits_left, n_bits_left;

    logic                     accept;
    t_phase                   ph_e;
    logic [HPOS_W-1:0]        hp_e;
    logic [ACC_W-1:0]         acc_e;
    logic [ACC_W-1:0]         acc_shift;
    logic [BITS_PER_CHAR-1:0] v;
    logic                     bad;
    logic                     prefix;
    logic                     do_finish;
    logic [ACC_W-1:0]         fin_n;
    logic [CNT_W-1:0]         fin_cnt;
    logic [CNT_W-1:0]         fin_cnt_m1;
    logic [PAIR_W-1:0]        prod;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        ph_e      = i_new_graph ? PH_HEADER : r_phase;
        hp_e      = i_new_graph ? '0 : r_hpos;
        acc_e     = i_new_graph ? '0 : r_acc;
        v         = BITS_PER_CHAR'(i_char_code - CODE_BIAS);
        bad       = (i_char_code < CODE_BIAS) || (i_char_code > CODE_TOP);
        prefix    = (i_char_code == CHAR_COLON) || (i_char_code == CHAR_AMP);
        acc_shift = {acc_e[ACC_W-BITS_PER_CHAR-1:0], v};
        fin_n     = (ph_e == PH_HEADER && hp_e == '0) ? ACC_W'(v) : acc_shift;
        fin_cnt    = fin_n[CNT_W-1:0];
        fin_cnt_m1 = fin_cnt - CNT_W'(1);
        prod       = PAIR_W'(fin_cnt) * PAIR_W'(fin_cnt_m1);

        n_phase     = r_phase;
        n_hpos      = r_hpos;
        n_acc       = r_acc;
        n_bits_left = r_bits_left;
        o_push      = 1'b0;
        o_cmd       = '0;
        do_finish   = 1'b0;

        if (accept && ph_e != PH_IDLE) begin
            n_phase = ph_e;
            n_hpos  = hp_e;
            n_acc   = acc_e;
            if (ph_e == PH_HEADER && hp_e == '0 && prefix) begin
                o_push    = 1'b1;
                o_cmd.kind = KIND_ERROR;
                o_cmd.err  = ERR_PREFIX;
                n_phase   = PH_IDLE;
            end else if (bad) begin
                o_push    = 1'b1;
                o_cmd.kind = KIND_ERROR;
                o_cmd.err  = ERR_BAD_CHAR;
                n_phase   = PH_IDLE;
            end else begin
                case (ph_e)
                    PH_HEADER: begin
                        if (hp_e == HPOS_W'(0)) begin
                            if (v != ESCAPE_VALUE) do_finish = 1'b1;
                            else n_hpos = HPOS_W'(1);
                        end else if (hp_e == HPOS_W'(1)) begin
                            if (v == ESCAPE_VALUE) begin
                                n_phase = PH_LONG;
                                n_hpos  = '0;
                                n_acc   = '0;
                            end else begin
                                n_acc  = ACC_W'(v);
                                n_hpos = HPOS_W'(2);
                            end
                        end else begin
                            n_acc = acc_shift;
                            if (hp_e >= HPOS_W'(3)) do_finish = 1'b1;
                            else n_hpos = hp_e + HPOS_W'(1);
                        end
                    end
                    PH_LONG: begin
                        n_acc = acc_shift;
                        if (hp_e >= HPOS_W'(5)) do_finish = 1'b1;
                        else n_hpos = hp_e + HPOS_W'(1);
                    end
                    PH_DATA: begin
                        o_push        = 1'b1;
                        o_cmd.is_data = 1'b1;
                        o_cmd.kind    = KIND_EDGE;
                        o_cmd.bits    = v;
                        if (r_bits_left <= PAIR_W'(BITS_PER_CHAR)) begin
                            o_cmd.nbits     = NBITS_W'(r_bits_left);
                            o_cmd.last_char = 1'b1;
                            n_phase         = PH_IDLE;
                        end else begin
                            o_cmd.nbits = NBITS_W'(BITS_PER_CHAR);
                            n_bits_left = r_bits_left - PAIR_W'(BITS_PER_CHAR);
                        end
                    end
                    default: ;
                endcase
            end

            if (do_finish) begin
                o_push = 1'b1;
                if (fin_n > ACC_W'(MAX_VERTICES)) begin
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err  = ERR_TOO_LARGE;
                    n_phase    = PH_IDLE;
                end else begin
                    o_cmd.kind  = KIND_SIZE;
                    o_cmd.count = fin_cnt;
                    n_hpos      = '0;
                    n_bits_left = prod >> 1;
                    n_phase     = (fin_cnt < CNT_W'(2)) ? PH_IDLE : PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hpos      <= '0;
            r_acc       <= '0;
            r_bits_left <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hpos      <= n_hpos;
            r_acc       <= n_acc;
            r_bits_left <= n_bits_left;
        end
    end

endmodule

// ----- rtl/gadu_cmdq.sv -----
// Short command queue between the front end and the back end.
module gadu_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gadu_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output gadu_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import gadu_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int FILL_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              do_pop;

    assign o_full  = (r_fill == FILL_W'(CMDQ_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !do_pop) n_fill = r_fill + FILL_W'(1);
        else if (!i_push && do_pop) n_fill = r_fill - FILL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ----- rtl/gadu_back.sv -----
// Back end: expands commands into results, walking the upper triangle.
module gadu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gadu_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output gadu_pkg::t_res o_res
);
    import gadu_pkg::*;

    logic               r_valid, n_valid;
    t_res               r_res, n_res;
    logic [NBITS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_n, n_n;

    logic load;
    logic last_bit;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        load     = i_valid && (!r_valid || i_ready);
        last_bit = (r_pos == i_cmd.nbits - NBITS_W'(1));

        n_valid = r_valid && !i_ready;
        n_res   = r_res;
        n_pos   = r_pos;
        n_row   = r_row;
        n_col   = r_col;
        n_n     = r_n;
        o_pop   = 1'b0;

        if (load) begin
            n_valid = 1'b1;
            n_res   = '0;
            if (!i_cmd.is_data) begin
                o_pop             = 1'b1;
                n_res.kind        = i_cmd.kind;
                n_res.error_code  = i_cmd.err;
                n_res.vertex_count = VC_W'(i_cmd.count);
                n_res.last_in_run = 1'b1;
                if (i_cmd.kind == KIND_SIZE) begin
                    n_n   = i_cmd.count;
                    n_row = '0;
                    n_col = CNT_W'(1);
                end
            end else begin
                n_res.kind         = KIND_EDGE;
                n_res.vertex_count = VC_W'(r_n);
                n_res.row          = IDX_W'(r_row);
                n_res.col          = IDX_W'(r_col);
                n_res.present      = i_cmd.bits[NBITS_W'(BITS_PER_CHAR - 1) - r_pos];
                n_res.last_in_run  = last_bit;
                n_res.graph_done   = last_bit && i_cmd.last_char;
                // column-ordered walk: finish column, then start the next one at row 0
                if (r_row + CNT_W'(1) == r_col) begin
                    n_col = r_col + CNT_W'(1);
                    n_row = '0;
                end else begin
                    n_row = r_row + CNT_W'(1);
                end
                if (last_bit) begin
                    o_pop = 1'b1;
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + NBITS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
            r_row   <= '0;
            r_col   <= CNT_W'(1);
            r_n     <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
            r_row   <= n_row;
            r_col   <= n_col;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

// ----- rtl/graph6_adjacency_decoder_unit.sv -----
// Path: a result is valid once its character has been written to the queue and then
// loaded into the output register.
// Throughput: one character per cycle while the two-entry queue has room; results
// leave at one per cycle while the output is ready, and a data character gives up to six results.
// Reset: synchronous, active low; clears decoder state, queue and output valid.
module graph6_adjacency_decoder_unit #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gadu_char_if.sink    i_in,
    gadu_res_if.source   o_out
);
    import gadu_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    t_res res;

    gadu_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_char_code (i_in.char_code),
        .i_new_graph (i_in.new_graph),
        .i_full      (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    gadu_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    gadu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.kind         = res.kind;
    assign o_out.vertex_count = res.vertex_count;
    assign o_out.row          = res.row;
    assign o_out.col          = res.col;
    assign o_out.present      = res.present;
    assign o_out.error_code   = res.error_code;
    assign o_out.last_in_run  = res.last_in_run;
    assign o_out.graph_done   = res.graph_done;

endmodule

// ----- rtl/gadu_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
`include "graph6_adjacency_decoder_unit_macros.svh"

module gadu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [gadu_pkg::KIND_W-1:0] i_kind,
    input logic [gadu_pkg::VC_W-1:0]   i_vertex_count,
    input logic [gadu_pkg::IDX_W-1:0]  i_row,
    input logic [gadu_pkg::IDX_W-1:0]  i_col,
    input logic                        i_present,
    input logic [gadu_pkg::ERR_W-1:0]  i_error_code,
    input logic                        i_last_in_run,
    input logic                        i_graph_done
);
    import gadu_pkg::*;

    logic [$bits(t_res)-1:0] res_bits;

    assign res_bits = {i_kind, i_vertex_count, i_row, i_col, i_present, i_error_code,
                       i_last_in_run, i_graph_done};

    // stalled result holds
    `GADU_ASSERT(a_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(res_bits), "result changed while stalled")

    // a run of edge bits is not broken up once started
    `GADU_ASSERT(a_run, i_clk, i_rst_n, i_valid && i_ready && i_kind == KIND_EDGE && !i_last_in_run |=> i_valid && i_kind == KIND_EDGE, "gap inside an edge run")

    // graph end is only flagged on the closing edge, which sits just above the diagonal
    `GADU_ASSERT(a_done, i_clk, i_rst_n, i_valid && i_graph_done |-> i_kind == KIND_EDGE && i_last_in_run && i_row + IDX_W'(1) == i_col, "graph end off a run boundary")

    // reset empties the output
    `GADU_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !i_valid, "output valid after reset")

endmodule

bind graph6_adjacency_decoder_unit gadu_checker u_gadu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_kind         (o_out.kind),
    .i_vertex_count (o_out.vertex_count),
    .i_row          (o_out.row),
    .i_col          (o_out.col),
    .i_present      (o_out.present),
    .i_error_code   (o_out.error_code),
    .i_last_in_run  (o_out.last_in_run),
    .i_graph_done   (o_out.graph_done)
);
